[sv/iptl_pkg.sv]
// iptl_pkg: shared constants, register codes and state type for the
// inverted page table translator. No dependencies.
package iptl_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int PID_W    = 16;
    localparam int PAGE_W   = 20;
    localparam int OFFSET_W = 16;
    localparam int ADDR_W   = 22;
    localparam int FRAME_W  = 6;
    localparam int STAMP_W  = 32;
    localparam int ENTRY_W  = PID_W + PAGE_W + STAMP_W;

    // configuration registers
    localparam int FSIZE_W = 17;
    localparam int PAGES_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FSIZE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b1;

    localparam logic [FSIZE_W-1:0] FRAME_SIZE_RESET = 17'd4096;
    localparam logic [PAGES_W-1:0] PAGES_RESET      = 7'd64;
    localparam logic [STAMP_W-1:0] COUNT_RESET      = 32'd1;

    // address arithmetic widths
    localparam int PROD_W = IDX_W + FSIZE_W;
    localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

[sv/iptl_ram.sv]
// iptl_ram: generic single-write, single-read synchronous ram with
// registered read data. No dependencies.
module iptl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/inverted_page_table_lru_core.sv]
// Inverted page table translator with least-recently-used replacement.
// One request at a time; a new one is accepted in the cycle of the done strobe.
// The scan reads the first n table entries, n being the clamped pages_in_use,
// one entry a cycle from the table ram. Reset clears all entries to zero
// through per-entry valid bits, sets the counter to one; the receiver cannot
// stall.
module inverted_page_table_lru_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [iptl_pkg::PID_W-1:0]    process_id,
    input  logic [iptl_pkg::PAGE_W-1:0]   page_number,
    input  logic [iptl_pkg::OFFSET_W-1:0] page_offset,
    output logic                          done,
    output logic [iptl_pkg::ADDR_W-1:0]   physical_address,
    output logic [iptl_pkg::FRAME_W-1:0]  frame_index,
    output logic                          page_fault,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [iptl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iptl_pkg::CFG_DATA_W-1:0] cfg_data
);

    import iptl_pkg::*;

    // fsm
    state_t state_reg, state_next;

    // configuration
    logic [FSIZE_W-1:0] frame_size_reg;
    logic [PAGES_W-1:0] pages_reg;

    // request
    logic [PID_W-1:0]    pid_reg, pid_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0]    n_reg, n_next;

    // scan
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   hit_reg, hit_next;
    logic [IDX_W-1:0]   oldest_reg, oldest_next;
    logic [STAMP_W-1:0] oldest_stamp_reg, oldest_stamp_next;

    // state outside the ram
    logic [STAMP_W-1:0] access_count_reg, access_count_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // results
    logic               done_reg, done_next;
    logic [ADDR_W-1:0]  paddr_reg, paddr_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               fault_reg, fault_next;

    // ram interface
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    // combinational helpers
    logic               accept;
    logic               scan_issue;
    logic               last_cmp;
    logic [CNT_W-1:0]   n_clamped;
    logic [ENTRY_W-1:0] entry;
    logic [PID_W-1:0]   entry_pid;
    logic [PAGE_W-1:0]  entry_page;
    logic [STAMP_W-1:0] entry_stamp;
    logic               entry_match;
    logic [IDX_W-1:0]   target;
    logic [PROD_W-1:0]  product;
    logic [SUM_W-1:0]   addr_sum;

    iptl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= FRAME_SIZE_RESET;
            pages_reg      <= PAGES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_SIZE:   frame_size_reg <= cfg_data[FSIZE_W-1:0];
                CFG_PAGES_IN_USE: pages_reg      <= cfg_data[PAGES_W-1:0];
            endcase
        end
    end

    // clamp entries in use to 1 .. ENTRIES
    always_comb
    begin
        if (pages_reg == '0)
        begin
            n_clamped = CNT_W'(1);
        end
        else if (32'(pages_reg) > ENTRIES)
        begin
            n_clamped = CNT_W'(ENTRIES);
        end
        else
        begin
            n_clamped = CNT_W'(pages_reg);
        end
    end

    // entry under compare, never-written entries read as zero
    assign entry       = valid_reg[cmp_idx_reg] ? ram_rdata : '0;
    assign entry_pid   = entry[ENTRY_W-1 -: PID_W];
    assign entry_page  = entry[STAMP_W +: PAGE_W];
    assign entry_stamp = entry[STAMP_W-1:0];
    assign entry_match = (entry_pid == pid_reg) && (entry_page == page_reg);
    assign last_cmp    = cmp_valid_reg && (({1'b0, cmp_idx_reg} + CNT_W'(1)) == n_reg);

    // replacement choice and address
    assign target   = found_reg ? hit_reg : oldest_reg;
    assign product  = PROD_W'(target) * PROD_W'(frame_size_reg);
    assign addr_sum = SUM_W'(product) + SUM_W'(offset_reg);

    // fsm next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        busy       = 1'b1;
        ram_we     = 1'b0;
        scan_issue = 1'b0;
        unique case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_SCAN:  scan_issue = (rd_idx_reg < n_reg);
            ST_WRITE: ram_we = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    assign accept    = start && !busy;
    assign ram_waddr = target;
    assign ram_wdata = {pid_reg, page_reg, access_count_reg};

    // datapath next values
    always_comb
    begin
        pid_next          = pid_reg;
        page_next         = page_reg;
        offset_next       = offset_reg;
        n_next            = n_reg;
        rd_idx_next       = rd_idx_reg;
        cmp_valid_next    = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        found_next        = found_reg;
        hit_next          = hit_reg;
        oldest_next       = oldest_reg;
        oldest_stamp_next = oldest_stamp_reg;
        access_count_next = access_count_reg;
        valid_next        = valid_reg;
        done_next         = 1'b0;
        paddr_next        = paddr_reg;
        frame_next        = frame_reg;
        fault_next        = fault_reg;

        // latch request
        if (accept)
        begin
            pid_next    = process_id;
            page_next   = page_number;
            offset_next = page_offset;
            n_next      = n_clamped;
            rd_idx_next = '0;
            found_next  = 1'b0;
            hit_next    = '0;
            oldest_next = '0;
        end

        // issue one read a cycle
        if (scan_issue)
        begin
            rd_idx_next    = rd_idx_reg + CNT_W'(1);
            cmp_valid_next = 1'b1;
            cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
        end

        // merged match and oldest search
        if (cmp_valid_reg)
        begin
            if (!found_reg && entry_match)
            begin
                found_next = 1'b1;
                hit_next   = cmp_idx_reg;
            end
            if ((cmp_idx_reg == '0) || (entry_stamp < oldest_stamp_reg))
            begin
                oldest_next       = cmp_idx_reg;
                oldest_stamp_next = entry_stamp;
            end
        end

        // write back stamp and register the result
        if (ram_we)
        begin
            valid_next[target] = 1'b1;
            access_count_next  = access_count_reg + STAMP_W'(1);
            done_next          = 1'b1;
            paddr_next         = addr_sum[ADDR_W-1:0];
            frame_next         = FRAME_W'(target);
            fault_next         = !found_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmp_valid_reg    <= 1'b0;
            access_count_reg <= COUNT_RESET;
            valid_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmp_valid_reg    <= cmp_valid_next;
            access_count_reg <= access_count_next;
            valid_reg        <= valid_next;
            done_reg         <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pid_reg          <= pid_next;
        page_reg         <= page_next;
        offset_reg       <= offset_next;
        n_reg            <= n_next;
        rd_idx_reg       <= rd_idx_next;
        cmp_idx_reg      <= cmp_idx_next;
        found_reg        <= found_next;
        hit_reg          <= hit_next;
        oldest_reg       <= oldest_next;
        oldest_stamp_reg <= oldest_stamp_next;
        paddr_reg        <= paddr_next;
        frame_reg        <= frame_next;
        fault_reg        <= fault_next;
    end

    // result ports
    assign done             = done_reg;
    assign physical_address = paddr_reg;
    assign frame_index      = frame_reg;
    assign page_fault       = fault_reg;

    // checks
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WRITE))
        else $error("result strobe without write-back");

    a_we_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WRITE))
        else $error("table written outside write-back");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start a scan");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (access_count_reg == $past(access_count_reg) + STAMP_W'(1)))
        else $error("access counter did not advance by one");

endmodule
